// File: rtl/yuv_ordered_dither_palette_mapper_macros.svh
// Assertion macros used by the checker file of the palette mapper.
`ifndef YUV_ORDERED_DITHER_PALETTE_MAPPER_MACROS_SVH
`define YUV_ORDERED_DITHER_PALETTE_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define YODPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("yodpm assertion failed");

// Next-cycle implication with an explicit disable condition.
`define YODPM_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("yodpm assertion failed");

`endif

// File: rtl/yodpm_pkg.sv
// Types, constants and helper functions of the YUV palette mapper.
`default_nettype none
package yodpm_pkg;

    localparam logic [1:0] MODE_GREY16  = 2'd0;
    localparam logic [1:0] MODE_GREY256 = 2'd1;
    localparam logic [1:0] MODE_DITHER  = 2'd2;

    localparam logic [7:0] REG_COLOR_MODE = 8'd0;
    localparam logic [7:0] REG_ALPHA_BYTE = 8'd1;

    localparam logic [1:0] COLOR_MODE_RST = MODE_DITHER;
    localparam logic [7:0] ALPHA_BYTE_RST = 8'hFF;

    localparam int Y_LEVELS = 10;
    localparam int C_LEVELS = 5;

    localparam logic [7:0] LUMA_DITHER   [4] = '{8'd12, 8'd19, 8'd25, 8'd6};
    localparam logic [7:0] CHROMA_DITHER [4] = '{8'd25, 8'd38, 8'd51, 8'd12};

    typedef logic signed [17:0] t_term;
    typedef logic signed [18:0] t_sum;

    // (centre - 16) * 298 + 128 for each luma level
    localparam t_term Y_BASE [10] = '{
        -18'sd4640, 18'sd2810, 18'sd10558, 18'sd18008, 18'sd25756,
        18'sd33206, 18'sd40954, 18'sd48404, 18'sd56152, 18'sd63602};
    // chroma level centre minus 128, scaled by each coefficient
    localparam t_term V_TO_R [5] = '{-18'sd52352, -18'sd31493, -18'sd10634,
                                     18'sd10225, 18'sd31084};
    localparam t_term U_TO_B [5] = '{-18'sd66048, -18'sd39732, -18'sd13416,
                                     18'sd12900, 18'sd39216};
    localparam t_term U_TO_G [5] = '{-18'sd12800, -18'sd7700, -18'sd2600,
                                     18'sd2500, 18'sd7600};
    localparam t_term V_TO_G [5] = '{-18'sd26624, -18'sd16016, -18'sd5408,
                                     18'sd5200, 18'sd15808};

    typedef struct packed {
        logic       dither;
        logic [7:0] grey_idx;
        logic [7:0] grey_val;
        logic [3:0] y_lvl;
        logic [2:0] u_lvl;
        logic [2:0] v_lvl;
    } t_entry;

    // floor(x / 255) for x below 4080
    function automatic logic [3:0] div255(input logic [11:0] x);
        logic [12:0] t;
        t = 13'(x) + 13'(x[11:8]) + 13'd1;
        return t[11:8];
    endfunction

    function automatic logic [7:0] clip8(input t_sum s);
        logic [7:0] r;
        if (s <= 0) begin
            r = 8'd0;
        end else if (s[17:16] != 2'b00) begin
            r = 8'hFF;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/yodpm_if.sv
// Valid/ready channel interfaces for pixels, results and configuration.
`default_nettype none
interface yodpm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       column_odd;
    logic       row_odd;

    modport source (output valid, luma, chroma_blue, chroma_red, column_odd, row_odd,
                    input ready);
    modport sink (input valid, luma, chroma_blue, chroma_red, column_odd, row_odd,
                  output ready);
endinterface

interface yodpm_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  palette_index;
    logic [31:0] argb_color;

    modport source (output valid, palette_index, argb_color, input ready);
    modport sink (input valid, palette_index, argb_color, output ready);
endinterface

interface yodpm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/yodpm_front.sv
// Front end: configuration registers, dither and level quantization.
`default_nettype none
module yodpm_front
    import yodpm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic [7:0] i_luma,
    input  wire logic [7:0] i_chroma_blue,
    input  wire logic [7:0] i_chroma_red,
    input  wire logic       i_column_odd,
    input  wire logic       i_row_odd,
    output t_entry          o_entry,
    output logic [7:0]      o_alpha_byte
);

    logic [1:0] r_color_mode;
    logic [7:0] r_alpha_byte;
    logic [1:0] pos;
    logic [8:0] y_sum, u_sum, v_sum;
    logic [11:0] y_prod, u_prod, v_prod;
    logic [3:0] y_q, u_q, v_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= COLOR_MODE_RST;
            r_alpha_byte <= ALPHA_BYTE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COLOR_MODE) begin
                r_color_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_index == REG_ALPHA_BYTE) begin
                r_alpha_byte <= i_cfg_data;
            end
        end
    end

    assign o_alpha_byte = r_alpha_byte;
    assign pos          = {i_row_odd, i_column_odd};

    always_comb begin
        y_sum  = 9'(i_luma) + 9'(LUMA_DITHER[pos]);
        u_sum  = 9'(i_chroma_blue) + 9'(CHROMA_DITHER[pos]);
        v_sum  = 9'(i_chroma_red) + 9'(CHROMA_DITHER[pos]);
        y_prod = 12'(y_sum) * 12'(Y_LEVELS);
        u_prod = 12'(u_sum) * 12'(C_LEVELS);
        v_prod = 12'(v_sum) * 12'(C_LEVELS);
        y_q    = div255(y_prod);
        u_q    = div255(u_prod);
        v_q    = div255(v_prod);

        o_entry.y_lvl = (y_q >= 4'(Y_LEVELS)) ? 4'(Y_LEVELS - 1) : y_q;
        o_entry.u_lvl = (u_q >= 4'(C_LEVELS)) ? 3'(C_LEVELS - 1) : u_q[2:0];
        o_entry.v_lvl = (v_q >= 4'(C_LEVELS)) ? 3'(C_LEVELS - 1) : v_q[2:0];

        unique case (r_color_mode)
            MODE_GREY16: begin
                o_entry.dither   = 1'b0;
                o_entry.grey_idx = 8'd0;
                o_entry.grey_val = {i_luma[7:4], 4'b0000};
            end
            MODE_GREY256: begin
                o_entry.dither   = 1'b0;
                o_entry.grey_idx = i_luma;
                o_entry.grey_val = i_luma;
            end
            default: begin
                o_entry.dither   = 1'b1;
                o_entry.grey_idx = i_luma;
                o_entry.grey_val = i_luma;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/yodpm_queue.sv
// Two-entry queue between the front end and the color back end.
`default_nettype none
module yodpm_queue
    import yodpm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_entry
);

    t_entry     r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_entry = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

// File: rtl/yodpm_back.sv
// Back end: palette index, BT.601 or grey color, output register.
`default_nettype none
module yodpm_back
    import yodpm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_entry     i_entry,
    input  wire logic [7:0] i_alpha_byte,
    output logic            o_pop,
    input  wire logic       i_ready,
    output logic            o_valid,
    output logic [7:0]      o_palette_index,
    output logic [31:0]     o_argb_color
);

    logic        r_valid;
    logic [7:0]  r_index;
    logic [31:0] r_argb;
    logic [7:0]  n_index;
    logic [23:0] n_rgb;
    t_sum        red_sum, grn_sum, blu_sum;
    t_term       base;

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        base    = Y_BASE[i_entry.y_lvl];
        red_sum = 19'(base) + 19'(V_TO_R[i_entry.v_lvl]);
        grn_sum = 19'(base) - 19'(U_TO_G[i_entry.u_lvl]) - 19'(V_TO_G[i_entry.v_lvl]);
        blu_sum = 19'(base) + 19'(U_TO_B[i_entry.u_lvl]);
        if (i_entry.dither) begin
            n_index = 8'd1 + 8'(i_entry.y_lvl) * 8'(C_LEVELS * C_LEVELS)
                    + 8'(i_entry.u_lvl) * 8'(C_LEVELS) + 8'(i_entry.v_lvl);
            n_rgb   = {clip8(red_sum), clip8(grn_sum), clip8(blu_sum)};
        end else begin
            n_index = i_entry.grey_idx;
            n_rgb   = {i_entry.grey_val, i_entry.grey_val, i_entry.grey_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_index <= n_index;
            r_argb  <= {i_alpha_byte, n_rgb};
        end
    end

    assign o_valid         = r_valid;
    assign o_palette_index = r_index;
    assign o_argb_color    = r_argb;

endmodule
`default_nettype wire

// File: rtl/yuv_ordered_dither_palette_mapper.sv
// An accepted pixel is written into the queue, then popped into the output register
// once that register is empty or being taken. Throughput: one pixel per cycle while
// the sink is ready, as the back end drains one queue entry per cycle.
// The front end stalls only when the two-entry queue is full.
// Reset: synchronous active low; color_mode returns to 2, alpha_byte to 255,
// the queue and the output register are emptied.
`default_nettype none
module yuv_ordered_dither_palette_mapper
    import yodpm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    yodpm_cfg_if.sink  i_cfg,
    yodpm_pix_if.sink  i_pix,
    yodpm_res_if.source o_res
);

    t_entry     front_entry;
    t_entry     queue_entry;
    logic [7:0] alpha_byte;
    logic       queue_full, queue_valid, queue_pop, pix_push;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !queue_full;
    assign pix_push    = i_pix.valid && !queue_full;

    yodpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_luma        (i_pix.luma),
        .i_chroma_blue (i_pix.chroma_blue),
        .i_chroma_red  (i_pix.chroma_red),
        .i_column_odd  (i_pix.column_odd),
        .i_row_odd     (i_pix.row_odd),
        .o_entry       (front_entry),
        .o_alpha_byte  (alpha_byte)
    );

    yodpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_push),
        .i_entry (front_entry),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_entry (queue_entry)
    );

    yodpm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (queue_valid),
        .i_entry         (queue_entry),
        .i_alpha_byte    (alpha_byte),
        .o_pop           (queue_pop),
        .i_ready         (o_res.ready),
        .o_valid         (o_res.valid),
        .o_palette_index (o_res.palette_index),
        .o_argb_color    (o_res.argb_color)
    );

endmodule
`default_nettype wire

// File: rtl/yodpm_checker.sv
// Port-level checker for the palette mapper and its bind to the top level.
`default_nettype none
`include "yuv_ordered_dither_palette_mapper_macros.svh"
module yodpm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_out_index,
    input wire logic [31:0] i_out_argb
);

    logic [2:0]  r_inflight;
    logic        in_xfer, out_xfer;
    logic        out_stall, count_ok;
    logic        index_zero, index_high, nib_grey, full_grey;
    logic [39:0] out_word;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    assign out_stall  = i_out_valid && !i_out_ready;
    assign out_word   = {i_out_index, i_out_argb};
    assign count_ok   = r_inflight != 3'd0 && r_inflight <= 3'd3;
    assign index_zero = i_out_valid && i_out_index == 8'd0;
    assign index_high = i_out_valid && i_out_index > 8'd250;
    assign nib_grey   = i_out_argb[23:16] == i_out_argb[7:0]
                     && i_out_argb[15:8] == i_out_argb[7:0]
                     && i_out_argb[3:0] == 4'd0;
    assign full_grey  = i_out_argb[23:16] == i_out_index
                     && i_out_argb[15:8] == i_out_index
                     && i_out_argb[7:0] == i_out_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else if (in_xfer && !out_xfer) begin
            r_inflight <= r_inflight + 3'd1;
        end else if (!in_xfer && out_xfer) begin
            r_inflight <= r_inflight - 3'd1;
        end
    end

    `YODPM_ASSERT_NEXT(a_empty_after_reset, i_clk, 1'b0, !i_rst_n, !i_out_valid)
    `YODPM_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, out_stall, i_out_valid && $stable(out_word))
    `YODPM_ASSERT_NOW(a_no_invented, i_clk, i_rst_n, i_out_valid, count_ok)
    `YODPM_ASSERT_NOW(a_index0_grey, i_clk, i_rst_n, index_zero, nib_grey)
    `YODPM_ASSERT_NOW(a_high_index_grey, i_clk, i_rst_n, index_high, full_grey)

endmodule

bind yuv_ordered_dither_palette_mapper yodpm_checker u_yodpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_index (o_res.palette_index),
    .i_out_argb  (o_res.argb_color)
);
`default_nettype wire

// File: bench/yodpm_tb_pkg.sv
// Pixel and result types plus the scoreboard that predicts the palette mapper output.
package yodpm_tb_pkg;
    import yodpm_pkg::*;

    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [7:0] REG_FIRST_UNUSED = 8'd2;
    localparam logic [7:0] REG_LAST         = 8'hFF;

    localparam int LUMA_STEPS   = 10;
    localparam int CHROMA_STEPS = 5;
    localparam int LUMA_OFFSET   [4] = '{12, 19, 25, 6};
    localparam int CHROMA_OFFSET [4] = '{25, 38, 51, 12};

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       column_odd;
        logic       row_odd;
    } t_pix;

    typedef struct packed {
        logic [7:0]  palette_index;
        logic [31:0] argb_color;
    } t_result;

    class palette_scoreboard;
        logic [1:0] color_mode;
        logic [7:0] alpha_byte;
        t_result    pending[$];
        int         errors;

        function new();
            color_mode = COLOR_MODE_RST;
            alpha_byte = ALPHA_BYTE_RST;
            errors     = 0;
        endfunction

        function void write_register(logic [7:0] idx, logic [7:0] data);
            if (idx == REG_COLOR_MODE) begin
                color_mode = data[1:0];
            end else if (idx == REG_ALPHA_BYTE) begin
                alpha_byte = data;
            end
        endfunction

        static function int quantize(int sample, int offset, int steps);
            int q;
            q = (sample + offset) * steps / 255;
            return (q >= steps) ? steps - 1 : q;
        endfunction

        static function logic [7:0] clip_channel(int sum);
            if (sum <= 0) begin
                return 8'd0;
            end else if ((sum >>> 8) > 255) begin
                return 8'hFF;
            end
            return 8'(sum >>> 8);
        endfunction

        static function logic [23:0] level_color(int yl, int ul, int vl);
            int yc;
            int uc;
            int vc;
            int base;
            yc   = yl * 255 / LUMA_STEPS;
            uc   = ul * 255 / CHROMA_STEPS - 128;
            vc   = vl * 255 / CHROMA_STEPS - 128;
            base = (yc - 16) * 298 + 128;
            return {clip_channel(base + 409 * vc),
                    clip_channel(base - 100 * uc - 208 * vc),
                    clip_channel(base + 516 * uc)};
        endfunction

        function t_result map_pixel(t_pix p);
            t_result    r;
            int         pos;
            int         yl;
            int         ul;
            int         vl;
            logic [7:0] nib;
            pos = {p.row_odd, p.column_odd};
            case (color_mode)
                MODE_GREY16: begin
                    nib = p.luma & 8'hF0;
                    r.palette_index = 8'd0;
                    r.argb_color    = {alpha_byte, nib, nib, nib};
                end
                MODE_GREY256: begin
                    r.palette_index = p.luma;
                    r.argb_color    = {alpha_byte, p.luma, p.luma, p.luma};
                end
                default: begin
                    yl = quantize(p.luma, LUMA_OFFSET[pos], LUMA_STEPS);
                    ul = quantize(p.chroma_blue, CHROMA_OFFSET[pos], CHROMA_STEPS);
                    vl = quantize(p.chroma_red, CHROMA_OFFSET[pos], CHROMA_STEPS);
                    r.palette_index = 8'(1 + yl * CHROMA_STEPS * CHROMA_STEPS
                                      + ul * CHROMA_STEPS + vl);
                    r.argb_color    = {alpha_byte, level_color(yl, ul, vl)};
                end
            endcase
            return r;
        endfunction

        function void note_pixel(t_pix p);
            pending.push_back(map_pixel(p));
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result index %0d argb %08h",
                                 got.palette_index, got.argb_color));
                return;
            end
            want = pending.pop_front();
            if (got.palette_index !== want.palette_index) begin
                report($sformatf("palette_index got %0d want %0d",
                                 got.palette_index, want.palette_index));
            end
            if (got.argb_color !== want.argb_color) begin
                report($sformatf("argb_color got %08h want %08h",
                                 got.argb_color, want.argb_color));
            end
        endtask
    endclass

endpackage

// File: bench/tb_top.sv
// Top-level testbench driving pixels and register writes into the palette mapper.
module tb_top;
    import yodpm_pkg::*;
    import yodpm_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC        = 0;
    localparam int SNK        = 1;
    localparam int STALL_MAX  = 1000;
    localparam int SETTLE     = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;

    yodpm_cfg_if cfg_ch ();
    yodpm_pix_if pix_ch ();
    yodpm_res_if res_ch ();

    yuv_ordered_dither_palette_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    palette_scoreboard sb;
    int run_left [2] = '{0, 0};
    bit calm     [2] = '{0, 0};
    int idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    function automatic int draw_wait(int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(4, 40);
            calm[side]     = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input t_pix p);
        int gap;
        gap = draw_wait(SRC);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.luma        <= p.luma;
        pix_ch.chroma_blue <= p.chroma_blue;
        pix_ch.chroma_red  <= p.chroma_red;
        pix_ch.column_odd  <= p.column_odd;
        pix_ch.row_odd     <= p.row_odd;
        pix_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        sb.note_pixel(p);
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        sb.write_register(idx, data);
    endtask

    task automatic configure(input logic [7:0] mode_data, input logic [7:0] alpha,
                             input bit stray, input logic [7:0] stray_idx,
                             input logic [7:0] stray_data);
        wait_idle();
        if (stray) begin
            write_reg(stray_idx, stray_data);
        end
        write_reg(REG_COLOR_MODE, mode_data);
        write_reg(REG_ALPHA_BYTE, alpha);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold ready low for a random count per result, then take one transfer
    initial begin
        int wait_cycles;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = draw_wait(SNK);
            if (wait_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            sb.check_result('{res_ch.palette_index, res_ch.argb_color});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_MAX) begin
            $display("yuv_ordered_dither_palette_mapper regression: fail");
            $finish;
        end
    end

    initial begin
        logic [1:0] mode;
        logic [7:0] alpha;
        logic [1:0] pos;
        t_pix       p;
        sb = new();
        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.luma        <= 8'd0;
        pix_ch.chroma_blue <= 8'd0;
        pix_ch.chroma_red  <= 8'd0;
        pix_ch.column_odd  <= 1'b0;
        pix_ch.row_odd     <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= 8'd0;
        cfg_ch.data        <= 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dither mode out of reset: extremes at every parity, clamping and clipping
        for (int i = 0; i < 4; i++) begin
            pos = 2'(i);
            send_pixel('{8'h00, 8'h00, 8'h00, pos[0], pos[1]});
            send_pixel('{8'hFF, 8'hFF, 8'hFF, pos[0], pos[1]});
        end
        send_pixel('{8'hFF, 8'h00, 8'h00, 1'b0, 1'b0});
        send_pixel('{8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1});
        send_pixel('{8'h80, 8'h80, 8'h80, 1'b1, 1'b0});
        send_pixel('{8'h10, 8'hC8, 8'h3C, 1'b0, 1'b1});

        // grey16, with a write to an unmapped register that must be dropped
        configure({6'b101010, MODE_GREY16}, 8'h00, 1'b1, REG_FIRST_UNUSED, 8'h00);
        send_pixel('{8'hFF, 8'h12, 8'h34, 1'b1, 1'b1});
        send_pixel('{8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0});
        send_pixel('{8'h5A, 8'hA5, 8'h0F, 1'b1, 1'b0});

        // grey256
        configure({6'b010101, MODE_GREY256}, 8'hA5, 1'b1, REG_LAST, 8'hFF);
        send_pixel('{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1});
        send_pixel('{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1});
        send_pixel('{8'h81, 8'h7E, 8'h42, 1'b0, 1'b0});

        // unused mode code falls back to dithering
        configure({6'b111111, MODE_UNUSED}, 8'hFF, 1'b0, REG_LAST, 8'h00);
        send_pixel('{8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0});
        send_pixel('{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1});
        send_pixel('{8'h7F, 8'h80, 8'h81, 1'b1, 1'b1});

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: mode = MODE_DITHER;
                1: mode = MODE_GREY16;
                2: mode = MODE_GREY256;
                3: mode = MODE_DITHER;
                4: mode = MODE_UNUSED;
                default: mode = ($urandom_range(0, 1) == 0) ? MODE_DITHER
                                                            : 2'($urandom_range(0, 3));
            endcase
            alpha = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            configure({6'($urandom_range(0, 63)), mode}, alpha, $urandom_range(0, 1) == 1,
                      8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
            for (int k = 0; k < 150; k++) begin
                if (ph == 3 && k == 75) begin
                    wait_idle();
                end
                p.luma        = rand_sample();
                p.chroma_blue = rand_sample();
                p.chroma_red  = rand_sample();
                p.column_odd  = 1'($urandom_range(0, 1));
                p.row_odd     = 1'($urandom_range(0, 1));
                send_pixel(p);
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("yuv_ordered_dither_palette_mapper regression: pass");
        end else begin
            $display("yuv_ordered_dither_palette_mapper regression: fail");
        end
        $finish;
    end

endmodule
